/* sv/urm_pkg.sv */
// Shared types and constants of the 16550-style UART register model.
// Used by urm_regs and uart_register_model_unit; depends on nothing.
package urm_pkg;

    // Request kinds carried on the mode field.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_RECV  = 2'd2;
    localparam logic [1:0] MODE_IDLE  = 2'd3;

    // Register offsets from the UART base.
    localparam logic [2:0] OFF_DATA = 3'd0;
    localparam logic [2:0] OFF_IER  = 3'd1;
    localparam logic [2:0] OFF_IIR  = 3'd2;
    localparam logic [2:0] OFF_LCR  = 3'd3;
    localparam logic [2:0] OFF_MCR  = 3'd4;
    localparam logic [2:0] OFF_LSR  = 3'd5;
    localparam logic [2:0] OFF_MSR  = 3'd6;
    localparam logic [2:0] OFF_SCR  = 3'd7;

    // Interrupt identification codes.
    localparam logic [3:0] IID_NONE = 4'd1;
    localparam logic [3:0] IID_THRE = 4'd2;
    localparam logic [3:0] IID_RDA  = 4'd4;
    localparam logic [3:0] IID_RLS  = 4'd6;

    // Bit positions in LCR, IER and FCR.
    localparam int LCR_DLAB_BIT   = 7;
    localparam int IER_RDA_BIT    = 0;
    localparam int IER_THRE_BIT   = 1;
    localparam int IER_RLS_BIT    = 2;
    localparam int FCR_RXRST_BIT  = 1;

    // Fixed LSR bits: transmitter holding register empty and transmitter empty.
    localparam logic [7:0] LSR_TX_EMPTY = 8'h60;

    // Result of one request as handed from the register file to the output stage.
    typedef struct packed {
        logic        ring_sel;
        logic [15:0] read_data;
        logic        irq_assert;
        logic        tx_valid;
        logic [7:0]  tx_byte;
    } res_t;

endpackage

/* sv/uart_register_model_unit.sv */
// Top level of the 16550-style UART register model: handshakes and output stage.
// Depends on urm_pkg, urm_regs and urm_rx_ring.
//
// Takes one request per cycle (bus read, bus write or received byte) while no held
// result is stalled, and returns one result per request in the next cycle. All
// register updates happen at the accepting edge; the receive ring lives in a
// single-port-read synchronous memory that is read at that edge, and its registered
// data feeds the output stage directly. A single output register holds the result;
// a new request is taken in the same cycle as the held result is taken.
// Configuration writes are always ready.
module uart_register_model_unit #(
    parameter int RX_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [2:0]  reg_offset,
    input  logic        wide_access,
    input  logic [15:0] write_data,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] read_data,
    output logic        irq_assert,
    output logic        tx_valid,
    output logic [7:0]  tx_byte
);

    import urm_pkg::*;

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    logic             accept;
    res_t             res;
    res_t             res_reg;
    logic             out_valid_reg;
    logic             ring_we;
    logic [PTR_W-1:0] ring_waddr;
    logic [7:0]       ring_wdata;
    logic             ring_re;
    logic [PTR_W-1:0] ring_raddr;
    logic [7:0]       ring_q;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    urm_regs #(
        .RX_DEPTH (RX_DEPTH),
        .PTR_W    (PTR_W)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .mode        (mode),
        .reg_offset  (reg_offset),
        .wide_access (wide_access),
        .write_data  (write_data),
        .rx_byte     (rx_byte),
        .res         (res),
        .ring_we     (ring_we),
        .ring_waddr  (ring_waddr),
        .ring_wdata  (ring_wdata),
        .ring_re     (ring_re),
        .ring_raddr  (ring_raddr)
    );

    urm_rx_ring #(
        .DEPTH  (RX_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk   (clk),
        .we    (accept && ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .q     (ring_q)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload captured with the request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    // Ring data joins the result on the way out.
    assign out_valid  = out_valid_reg;
    assign read_data  = res_reg.ring_sel ? {8'h00, ring_q} : res_reg.read_data;
    assign irq_assert = res_reg.irq_assert;
    assign tx_valid   = res_reg.tx_valid;
    assign tx_byte    = res_reg.tx_byte;

    // Every accepted request leaves a result pending in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted request produced no result");

    // No request is taken while a held result is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !accept)
        else $error("request accepted over a stalled result");

    // Ring data is only selected for a data-register read.
    a_ring_sel: assert property (@(posedge clk) disable iff (!rst_n)
        res.ring_sel |-> (mode == MODE_READ) && (reg_offset == OFF_DATA))
        else $error("ring selected outside a data read");

endmodule

/* sv/urm_rx_ring.sv */
// Receive ring storage: one synchronous memory, one write and one read port.
// Read data is registered and appears in the cycle after the read. No package use.
module urm_rx_ring #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        q
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q_reg <= mem[raddr];
        end
    end

    assign q = q_reg;

endmodule

/* sv/urm_regs.sv */
// UART register file, ring pointers and interrupt identification logic.
// Depends on urm_pkg; drives the ring memory addresses and the result fields.
module urm_regs #(
    parameter int RX_DEPTH = 16,
    parameter int PTR_W    = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               accept,
    input  logic [1:0]         mode,
    input  logic [2:0]         reg_offset,
    input  logic               wide_access,
    input  logic [15:0]        write_data,
    input  logic [7:0]         rx_byte,
    output urm_pkg::res_t      res,
    output logic               ring_we,
    output logic [PTR_W-1:0]   ring_waddr,
    output logic [7:0]         ring_wdata,
    output logic               ring_re,
    output logic [PTR_W-1:0]   ring_raddr
);

    import urm_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

    logic [7:0]       div_lo_reg, div_lo_next;
    logic [7:0]       div_hi_reg, div_hi_next;
    logic [7:0]       ier_reg, ier_next;
    logic [7:0]       lcr_reg, lcr_next;
    logic [7:0]       mcr_reg, mcr_next;
    logic [7:0]       scr_reg, scr_next;
    logic             dr_reg, dr_next;
    logic             oe_reg, oe_next;
    logic [3:0]       iid_reg, iid_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic             fwd_reg;

    logic             dlab;
    logic [7:0]       lo;
    logic [PTR_W-1:0] wr_inc;
    logic [PTR_W-1:0] rd_inc;
    res_t             res_c;

    assign dlab   = lcr_reg[LCR_DLAB_BIT];
    assign lo     = write_data[7:0];
    assign wr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;

    // Decode the request and work out every register's next value.
    always_comb
    begin
        div_lo_next = div_lo_reg;
        div_hi_next = div_hi_reg;
        ier_next    = ier_reg;
        lcr_next    = lcr_reg;
        mcr_next    = mcr_reg;
        scr_next    = scr_reg;
        dr_next     = dr_reg;
        oe_next     = oe_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        res_c       = '0;
        ring_we     = 1'b0;

        case (mode)
            MODE_READ:
            begin
                case (reg_offset)
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            res_c.read_data = {(wide_access ? div_hi_reg : 8'h00), div_lo_reg};
                        end
                        else
                        begin
                            // Pop the ring when it holds data; DR drops once it drains.
                            if (rd_ptr_reg != wr_ptr_reg)
                            begin
                                res_c.ring_sel = 1'b1;
                                rd_ptr_next    = rd_inc;
                            end
                            if (rd_ptr_next == wr_ptr_reg)
                            begin
                                dr_next = 1'b0;
                            end
                        end
                    end
                    OFF_IER: res_c.read_data = {8'h00, (dlab ? div_hi_reg : ier_reg)};
                    OFF_IIR: res_c.read_data = {12'h000, iid_reg};
                    OFF_LCR: res_c.read_data = {8'h00, lcr_reg};
                    OFF_MCR: res_c.read_data = {8'h00, mcr_reg};
                    OFF_LSR:
                    begin
                        res_c.read_data = {8'h00, LSR_TX_EMPTY | {6'b0, oe_reg, dr_reg}};
                        oe_next         = 1'b0;
                    end
                    OFF_MSR: res_c.read_data = 16'h0000;
                    OFF_SCR: res_c.read_data = {8'h00, scr_reg};
                    default: res_c.read_data = 16'h0000;
                endcase
            end
            MODE_WRITE:
            begin
                case (reg_offset)
                    OFF_DATA:
                    begin
                        if (dlab)
                        begin
                            div_lo_next = lo;
                            if (wide_access)
                            begin
                                div_hi_next = write_data[15:8];
                            end
                        end
                        else if (fwd_reg)
                        begin
                            res_c.tx_valid = 1'b1;
                            res_c.tx_byte  = lo;
                        end
                    end
                    OFF_IER:
                    begin
                        if (dlab)
                        begin
                            div_hi_next = lo;
                        end
                        else
                        begin
                            ier_next = lo;
                        end
                    end
                    OFF_IIR:
                    begin
                        // FCR: only the receive reset bit acts.
                        if (lo[FCR_RXRST_BIT])
                        begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                            dr_next     = 1'b0;
                            oe_next     = 1'b0;
                        end
                    end
                    OFF_LCR: lcr_next = lo;
                    OFF_MCR: mcr_next = lo;
                    OFF_SCR: scr_next = lo;
                    default: ;
                endcase
            end
            MODE_RECV:
            begin
                // Store the byte; a full ring is an overrun that empties it.
                ring_we = 1'b1;
                if (wr_inc == rd_ptr_reg)
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    oe_next     = 1'b1;
                end
                else
                begin
                    wr_ptr_next = wr_inc;
                end
                dr_next = 1'b1;
            end
            default: ;
        endcase

        // Interrupt identification by priority from the updated state.
        if (ier_next[IER_RLS_BIT] && oe_next)
        begin
            iid_next = IID_RLS;
        end
        else if (ier_next[IER_RDA_BIT] && dr_next)
        begin
            iid_next = IID_RDA;
        end
        else if (ier_next[IER_THRE_BIT])
        begin
            iid_next = IID_THRE;
        end
        else
        begin
            iid_next = IID_NONE;
        end
        res_c.irq_assert = (iid_next != IID_NONE);
    end

    assign res        = res_c;
    assign ring_waddr = wr_ptr_reg;
    assign ring_wdata = rx_byte;
    assign ring_raddr = rd_ptr_reg;
    assign ring_re    = accept && res_c.ring_sel;

    // Register file update on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_lo_reg <= '0;
            div_hi_reg <= '0;
            ier_reg    <= '0;
            lcr_reg    <= '0;
            mcr_reg    <= '0;
            scr_reg    <= '0;
            dr_reg     <= 1'b0;
            oe_reg     <= 1'b0;
            iid_reg    <= IID_NONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (accept)
        begin
            div_lo_reg <= div_lo_next;
            div_hi_reg <= div_hi_next;
            ier_reg    <= ier_next;
            lcr_reg    <= lcr_next;
            mcr_reg    <= mcr_next;
            scr_reg    <= scr_next;
            dr_reg     <= dr_next;
            oe_reg     <= oe_next;
            iid_reg    <= iid_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Transmit forwarding control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            fwd_reg <= cfg_wdata;
        end
    end

    // Pointers never leave the ring.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= PTR_LAST) && (rd_ptr_reg <= PTR_LAST))
        else $error("ring pointer beyond ring depth");

    // With DR clear the ring must be empty.
    a_dr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !dr_reg |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("ring holds data while DR is clear");

    // OE is only raised by a received byte.
    a_oe_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(oe_reg) |-> $past(accept && (mode == MODE_RECV)))
        else $error("OE set without a received byte");

    // A ring pop always comes with a pointer advance.
    a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
        ring_re |=> (rd_ptr_reg != $past(rd_ptr_reg)))
        else $error("ring pop without read pointer advance");

endmodule
